@@ hdl/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types, constants and fixed-point helpers of the GGX reflectance core.
// ----------------------------------------------------------------------------
package ctb_pkg;

  typedef logic [31:0] q30_t;

  typedef enum logic [2:0] {
    REG_ALB_RED   = 3'd0,
    REG_ALB_GREEN = 3'd1,
    REG_ALB_BLUE  = 3'd2,
    REG_METAL     = 3'd3,
    REG_ROUGH     = 3'd4
  } reg_idx_e;

  localparam q30_t        ONE_Q30     = 32'h4000_0000;
  localparam q30_t        PI_Q30      = 32'd3373259426;
  localparam q30_t        INV_PI_Q30  = 32'd341782638;
  localparam q30_t        F0_BASE_Q30 = 32'd42949673;
  localparam q30_t        EPS_D_Q30   = 32'd107;
  localparam q30_t        EPS_DEN_Q30 = 32'd1074;
  localparam logic [15:0] ROUGH_LIMIT = 16'd29492;
  localparam logic [15:0] METAL_LIMIT = 16'd3276;
  localparam logic [15:0] Q15_ONE     = 16'h8000;

  // q30 product rounded half up, callers keep results below 2^32
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic [63:0] s;
    s = 64'(a) * 64'(b) + 64'h2000_0000;
    return s[61:30];
  endfunction

  // saturate at 1.0 and round to q1.15
  function automatic logic [15:0] to_q15(input q30_t v);
    q30_t s;
    s = ((v > ONE_Q30) ? ONE_Q30 : v) + 32'h0000_4000;
    return s[30:15];
  endfunction

endpackage

@@ hdl/cook_torrance_brdf_eval_core.sv @@
// ----------------------------------------------------------------------------
// cook_torrance_brdf_eval_core
// GGX / Schlick / Smith reflectance of one view-light-normal triple per cycle.
// Done follows start through the chain of square root, half-vector projection,
// GGX divide and specular divide.
// Throughput: one item per cycle, busy_o never rises; the receiver cannot stall.
// Reset clears the valid pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module cook_torrance_brdf_eval_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  input  logic signed [15:0] light_x_i,
  input  logic signed [15:0] light_y_i,
  input  logic signed [15:0] light_z_i,
  input  logic signed [15:0] surf_normal_x_i,
  input  logic signed [15:0] surf_normal_y_i,
  input  logic signed [15:0] surf_normal_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               done_o,
  output logic [15:0]        refl_red_o,
  output logic [15:0]        refl_green_o,
  output logic [15:0]        refl_blue_o,
  output logic               lambert_only_o
);

  import ctb_pkg::*;

  localparam int unsigned SQRT_LAT = 24;
  localparam int unsigned PROJ_QW  = 31;
  localparam int unsigned D_QW     = 55;
  localparam int unsigned G_QW     = 32;
  localparam int unsigned S_QW     = 30;

  localparam int unsigned S_SUM   = 3;
  localparam int unsigned S_COS   = 4;
  localparam int unsigned S_LEN   = S_SUM + SQRT_LAT;
  localparam int unsigned S_PROJ  = S_LEN + PROJ_QW;
  localparam int unsigned S_NH    = S_PROJ + 1;
  localparam int unsigned S_FT    = S_NH + 4;
  localparam int unsigned S_DDEN  = S_NH + 4;
  localparam int unsigned S_KD    = S_FT + 1;
  localparam int unsigned S_DTERM = S_DDEN + D_QW;
  localparam int unsigned S_G5    = S_COS + 1;
  localparam int unsigned S_GT    = S_G5 + G_QW + 1;
  localparam int unsigned S_NUM   = S_DTERM + 2;
  localparam int unsigned S_SIN   = S_NUM + 1;
  localparam int unsigned S_SQ    = S_SIN + S_QW;
  localparam int unsigned S_SPEC  = S_SQ + 1;
  localparam int unsigned LAT     = S_SPEC + 1;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  function automatic q30_t cos_q30(input logic signed [33:0] d);
    if (d <= 0) begin
      return '0;
    end else if (d >= 34'sd268435456) begin
      return ONE_Q30;
    end else begin
      return {2'b00, d[27:0], 2'b00};
    end
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers and derived material constants
  // --------------------------------------------------------------------------
  logic [15:0] alb_q [3];
  logic [15:0] metal_q, rough_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alb_q[0] <= Q15_ONE;
      alb_q[1] <= Q15_ONE;
      alb_q[2] <= Q15_ONE;
      metal_q  <= '0;
      rough_q  <= Q15_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ALB_RED:   alb_q[0] <= cfg_data_i;
        REG_ALB_GREEN: alb_q[1] <= cfg_data_i;
        REG_ALB_BLUE:  alb_q[2] <= cfg_data_i;
        REG_METAL:     metal_q  <= cfg_data_i;
        REG_ROUGH:     rough_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0] rough_s, metal_s;
  logic [16:0] rp_w;
  q30_t        mq_w;
  q30_t        r2_q, alpha2_q, oma2_q, k_q, omk_q, f0_q, omf0_q, ommq_q;
  q30_t        lam_q [3];
  logic        lamb_q;
  logic [63:0] a4_w;
  logic [33:0] rp2_w;

  assign rough_s = sat16(rough_q);
  assign metal_s = sat16(metal_q);
  assign rp_w    = {1'b0, rough_s} + 17'h0_8000;
  assign mq_w    = {1'b0, metal_s, 15'b0};
  assign a4_w    = 64'(r2_q) * 64'(r2_q);
  assign rp2_w   = 34'(rp_w) * 34'(rp_w) + 34'd4;

  // static only if the user writes while no items are in flight; not enforced
  always_ff @(posedge clk_i) begin
    r2_q     <= 32'(rough_s) * 32'(rough_s);
    alpha2_q <= a4_w[61:30];
    oma2_q   <= ONE_Q30 - alpha2_q;
    k_q      <= 32'(rp2_w >> 3);
    omk_q    <= ONE_Q30 - k_q;
    f0_q     <= F0_BASE_Q30 + mul30(ONE_Q30 - F0_BASE_Q30, mq_w);
    omf0_q   <= ONE_Q30 - f0_q;
    ommq_q   <= ONE_Q30 - mq_w;
    for (int c = 0; c < 3; c++) begin
      lam_q[c] <= mul30({1'b0, sat16(alb_q[c]), 15'b0}, INV_PI_Q30);
    end
    lamb_q   <= (rough_s >= ROUGH_LIMIT) && (metal_s <= METAL_LIMIT);
  end

  // --------------------------------------------------------------------------
  // valid pipeline
  // --------------------------------------------------------------------------
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i & ~busy_o};
    end
  end

  assign done_o = vld_q[LAT-1];

  // --------------------------------------------------------------------------
  // dot products
  // --------------------------------------------------------------------------
  logic signed [15:0] wo_q [3];
  logic signed [15:0] wi_q [3];
  logic signed [15:0] nv_q [3];
  logic signed [16:0] h_w  [3];
  logic        [32:0] hh_p_q [3];
  logic signed [32:0] nh_p_q [3];
  logic signed [32:0] hv_p_q [3];
  logic signed [31:0] nvv_p_q [3];
  logic signed [31:0] nl_p_q  [3];
  logic signed [33:0] hsq_w [3];
  logic        [33:0] hh_q;
  logic signed [34:0] dnh_q, dhv_q;
  logic signed [33:0] dnv_q, dnl_q;

  always_ff @(posedge clk_i) begin
    wo_q[0] <= view_x_i;
    wo_q[1] <= view_y_i;
    wo_q[2] <= view_z_i;
    wi_q[0] <= light_x_i;
    wi_q[1] <= light_y_i;
    wi_q[2] <= light_z_i;
    nv_q[0] <= surf_normal_x_i;
    nv_q[1] <= surf_normal_y_i;
    nv_q[2] <= surf_normal_z_i;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_w[i]   = 17'(wo_q[i]) + 17'(wi_q[i]);
      hsq_w[i] = 34'(h_w[i]) * 34'(h_w[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      hh_p_q[i]  <= hsq_w[i][32:0];
      nh_p_q[i]  <= 33'(nv_q[i]) * 33'(h_w[i]);
      hv_p_q[i]  <= 33'(h_w[i]) * 33'(wo_q[i]);
      nvv_p_q[i] <= 32'(wo_q[i]) * 32'(nv_q[i]);
      nl_p_q[i]  <= 32'(wi_q[i]) * 32'(nv_q[i]);
    end
    hh_q  <= 34'(hh_p_q[0]) + 34'(hh_p_q[1]) + 34'(hh_p_q[2]);
    dnh_q <= 35'(nh_p_q[0]) + 35'(nh_p_q[1]) + 35'(nh_p_q[2]);
    dhv_q <= 35'(hv_p_q[0]) + 35'(hv_p_q[1]) + 35'(hv_p_q[2]);
    dnv_q <= 34'(nvv_p_q[0]) + 34'(nvv_p_q[1]) + 34'(nvv_p_q[2]);
    dnl_q <= 34'(nl_p_q[0]) + 34'(nl_p_q[1]) + 34'(nl_p_q[2]);
  end

  // --------------------------------------------------------------------------
  // cosines, half-vector length and projections
  // --------------------------------------------------------------------------
  q30_t        ndv_q, ndl_q;
  logic [56:0] nnh_q, nhv_q, nnh_dly, nhv_dly;
  logic [23:0] len_w, pden_w;
  logic [30:0] qnh_w, qhv_w;
  q30_t        nh_q, hv_q;

  always_ff @(posedge clk_i) begin
    ndv_q <= cos_q30(dnv_q);
    ndl_q <= cos_q30(dnl_q);
    nnh_q <= (dnh_q > 0) ? {dnh_q[33:0], 23'b0} : '0;
    nhv_q <= (dhv_q > 0) ? {dhv_q[33:0], 23'b0} : '0;
  end

  ctb_isqrt #(.IW(48)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  ({hh_q, 14'b0}),
    .root_o (len_w)
  );

  ctb_delay #(.W(114), .N(S_LEN - S_COS)) u_dly_proj (
    .clk_i (clk_i),
    .d_i   ({nnh_q, nhv_q}),
    .q_o   ({nnh_dly, nhv_dly})
  );

  // opposite view and light: numerators are zero, keep the divisor nonzero
  assign pden_w = (len_w == '0) ? 24'd1 : len_w;

  ctb_div #(.NW(57), .DW(24), .QW(PROJ_QW)) u_div_nh (
    .clk_i (clk_i),
    .num_i (nnh_dly),
    .den_i (pden_w),
    .quo_o (qnh_w)
  );

  ctb_div #(.NW(57), .DW(24), .QW(PROJ_QW)) u_div_hv (
    .clk_i (clk_i),
    .num_i (nhv_dly),
    .den_i (pden_w),
    .quo_o (qhv_w)
  );

  always_ff @(posedge clk_i) begin
    nh_q <= (32'(qnh_w) > ONE_Q30) ? ONE_Q30 : 32'(qnh_w);
    hv_q <= (32'(qhv_w) > ONE_Q30) ? ONE_Q30 : 32'(qhv_w);
  end

  // --------------------------------------------------------------------------
  // ggx distribution and schlick fresnel
  // --------------------------------------------------------------------------
  q30_t om_w;
  q30_t nh2_q, t_q, tt_q, dden_q;
  q30_t om_q, om2_q, p2_q, p4_q, p5_q, fterm_q;
  logic [54:0] dterm_w;

  assign om_w = ONE_Q30 - hv_q;

  always_ff @(posedge clk_i) begin
    nh2_q   <= mul30(nh_q, nh_q);
    t_q     <= ONE_Q30 - mul30(nh2_q, oma2_q);
    tt_q    <= mul30(t_q, t_q);
    dden_q  <= mul30(tt_q, PI_Q30) + EPS_D_Q30;
    om_q    <= om_w;
    p2_q    <= mul30(om_w, om_w);
    p4_q    <= mul30(p2_q, p2_q);
    om2_q   <= om_q;
    p5_q    <= mul30(p4_q, om2_q);
    fterm_q <= f0_q + mul30(omf0_q, p5_q);
  end

  ctb_div #(.NW(61), .DW(32), .QW(D_QW)) u_div_d (
    .clk_i (clk_i),
    .num_i ({alpha2_q[30:0], 30'b0}),
    .den_i (dden_q),
    .quo_o (dterm_w)
  );

  // --------------------------------------------------------------------------
  // smith-schlick geometry and specular denominator
  // --------------------------------------------------------------------------
  logic [60:0] gnum_l_q, gnum_v_q;
  q30_t        gden_l_q, gden_v_q, gl_w, gv_w, gterm_q, gterm_dly;
  logic [32:0] den_q, den_dly;
  q30_t        ndvl_w;

  assign ndvl_w = mul30(ndv_q, ndl_q);

  always_ff @(posedge clk_i) begin
    gnum_l_q <= {ndl_q[30:0], 30'b0};
    gnum_v_q <= {ndv_q[30:0], 30'b0};
    gden_l_q <= mul30(ndl_q, omk_q) + k_q;
    gden_v_q <= mul30(ndv_q, omk_q) + k_q;
    den_q    <= 33'({ndvl_w, 2'b00}) + 33'(EPS_DEN_Q30);
  end

  ctb_div #(.NW(61), .DW(32), .QW(G_QW)) u_div_gl (
    .clk_i (clk_i),
    .num_i (gnum_l_q),
    .den_i (gden_l_q),
    .quo_o (gl_w)
  );

  ctb_div #(.NW(61), .DW(32), .QW(G_QW)) u_div_gv (
    .clk_i (clk_i),
    .num_i (gnum_v_q),
    .den_i (gden_v_q),
    .quo_o (gv_w)
  );

  always_ff @(posedge clk_i) begin
    gterm_q <= mul30(gl_w, gv_w);
  end

  ctb_delay #(.W(32), .N(S_FT - S_GT)) u_dly_g (
    .clk_i (clk_i),
    .d_i   (gterm_q),
    .q_o   (gterm_dly)
  );

  ctb_delay #(.W(33), .N(S_NUM - S_G5)) u_dly_den (
    .clk_i (clk_i),
    .d_i   (den_q),
    .q_o   (den_dly)
  );

  // --------------------------------------------------------------------------
  // specular term
  // --------------------------------------------------------------------------
  q30_t        kd_q, fg_q, fg_dly, kd_dly;
  logic [56:0] phi_q;
  logic [61:0] plo_q;
  logic [62:0] plo_r_w;
  logic [57:0] num_q;
  logic [62:0] snum_q;
  logic [32:0] sden_q;
  logic        sat_q, sat_dly;
  logic [29:0] spec_w;

  always_ff @(posedge clk_i) begin
    kd_q <= mul30(ONE_Q30 - fterm_q, ommq_q);
    fg_q <= mul30(fterm_q, gterm_dly);
  end

  ctb_delay #(.W(32), .N(S_DTERM - S_KD)) u_dly_fg (
    .clk_i (clk_i),
    .d_i   (fg_q),
    .q_o   (fg_dly)
  );

  // wide dterm times fg split into high and low partial products
  assign plo_r_w = (63'(plo_q) + 63'h2000_0000) >> 30;

  always_ff @(posedge clk_i) begin
    phi_q  <= 57'(dterm_w[54:30]) * 57'(fg_dly);
    plo_q  <= 62'(dterm_w[29:0]) * 62'(fg_dly);
    num_q  <= 58'(phi_q) + 58'(plo_r_w);
    sat_q  <= num_q >= 58'(den_dly);
    snum_q <= (num_q >= 58'(den_dly)) ? '0 : {num_q[32:0], 30'b0};
    sden_q <= den_dly;
  end

  ctb_div #(.NW(63), .DW(33), .QW(S_QW)) u_div_s (
    .clk_i (clk_i),
    .num_i (snum_q),
    .den_i (sden_q),
    .quo_o (spec_w)
  );

  ctb_delay #(.W(1), .N(S_SQ - S_SIN)) u_dly_sat (
    .clk_i (clk_i),
    .d_i   (sat_q),
    .q_o   (sat_dly)
  );

  ctb_delay #(.W(32), .N(S_SQ - S_KD)) u_dly_kd (
    .clk_i (clk_i),
    .d_i   (kd_q),
    .q_o   (kd_dly)
  );

  // --------------------------------------------------------------------------
  // channel sums and output register
  // --------------------------------------------------------------------------
  q30_t spec_q;
  q30_t m_q [3];

  always_ff @(posedge clk_i) begin
    spec_q <= sat_dly ? ONE_Q30 : 32'(spec_w);
    for (int c = 0; c < 3; c++) begin
      m_q[c] <= mul30(kd_dly, lam_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lamb_q) begin
      refl_red_o   <= to_q15(lam_q[0]);
      refl_green_o <= to_q15(lam_q[1]);
      refl_blue_o  <= to_q15(lam_q[2]);
    end else begin
      refl_red_o   <= to_q15(m_q[0] + spec_q);
      refl_green_o <= to_q15(m_q[1] + spec_q);
      refl_blue_o  <= to_q15(m_q[2] + spec_q);
    end
    lambert_only_o <= lamb_q;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("transfer did not complete after the pipeline latency");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (refl_red_o <= Q15_ONE && refl_green_o <= Q15_ONE &&
                refl_blue_o <= Q15_ONE))
    else $error("reflectance above 1.0");

  a_spec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_SPEC-1] |-> spec_q <= ONE_Q30)
    else $error("specular term above 1.0");

  a_proj_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_NH-1] |-> (nh_q <= ONE_Q30 && hv_q <= ONE_Q30))
    else $error("half-vector cosine above 1.0");

endmodule

@@ hdl/ctb_delay.sv @@
// ----------------------------------------------------------------------------
// ctb_delay
// Fixed-length shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module ctb_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < int'(N); i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

@@ hdl/ctb_div.sv @@
// ----------------------------------------------------------------------------
// ctb_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module ctb_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 4,
  parameter int unsigned QW = 4
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rin;
    logic [QW-1:0] lin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic          oin;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = DW'(num_i >> QW);
      assign lin = num_i[QW-1:0];
      assign din = den_i;
      assign qin = '0;
      // quotient would not fit, or divide by zero
      assign oin = CW'(num_i >> QW) >= CW'(den_i);
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign lin = low_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
      assign oin = ovf_q[k-1];
    end

    assign t  = {rin, lin[QW-1]};
    assign ge = t >= {1'b0, din};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DW'(t - {1'b0, din}) : t[DW-1:0];
      low_q[k] <= lin << 1;
      den_q[k] <= din;
      quo_q[k] <= {qin[QW-2:0], ge};
      ovf_q[k] <= oin;
    end
  end

  assign quo_o = ovf_q[QW-1] ? '1 : quo_q[QW-1];

endmodule

@@ hdl/ctb_isqrt.sv @@
// ----------------------------------------------------------------------------
// ctb_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ctb_isqrt #(
  parameter int unsigned IW = 48
) (
  input  logic            clk_i,
  input  logic [IW-1:0]   rad_i,
  output logic [IW/2-1:0] root_o
);

  localparam int unsigned RW = IW / 2;

  logic [IW-1:0] v_q [RW];
  logic [IW-1:0] r_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [IW-1:0] BITK = {{(IW-1){1'b0}}, 1'b1} << (IW - 2 - 2*k);
    logic [IW-1:0] vin;
    logic [IW-1:0] rin;
    logic [IW:0]   sum;
    logic          ge;

    if (k == 0) begin : g_first
      assign vin = rad_i;
      assign rin = '0;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign rin = r_q[k-1];
    end

    assign sum = {1'b0, rin} + {1'b0, BITK};
    assign ge  = {1'b0, vin} >= sum;

    always_ff @(posedge clk_i) begin
      v_q[k] <= ge ? vin - sum[IW-1:0] : vin;
      r_q[k] <= ge ? (rin >> 1) + BITK : rin >> 1;
    end
  end

  assign root_o = r_q[RW-1][RW-1:0];

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GGX reflectance core. Unit-vector and random
// queries go through the start handshake under several material settings,
// and every done strobe is compared with a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
module tb;
  import ctb_pkg::*;

  localparam int          NUM_REGS   = 5;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          DRAIN_WAIT = 200;
  localparam logic [63:0] Q30        = 64'h4000_0000;
  localparam logic [63:0] PI_C       = 64'd3373259426;
  localparam logic [63:0] INV_PI_C   = 64'd341782638;
  localparam logic [63:0] F0_C       = 64'd42949673;
  localparam logic [63:0] EPS_D      = 64'd107;
  localparam logic [63:0] EPS_DEN    = 64'd1074;

  typedef struct {
    logic signed [15:0] comp[9];  // view xyz, light xyz, normal xyz
  } query_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        lambert;
  } shade_t;

  class brdf_scoreboard;
    logic [15:0] mat_reg[NUM_REGS];
    shade_t      pending_shades[$];
    int          errors;
    int          checked;
    int          lambert_seen;

    function new();
      mat_reg = '{16'd32768, 16'd32768, 16'd32768, 16'd0, 16'd32768};
      errors  = 0;
      checked = 0;
      lambert_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx < NUM_REGS) mat_reg[idx] = val;
    endfunction

    function logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
      return (a >> 30) * b + (((a & (Q30 - 1)) * b + 64'h2000_0000) >> 30);
    endfunction

    function logic [63:0] clip_q15(int i);
      return (mat_reg[i] > 16'd32768) ? 64'd32768 : 64'(mat_reg[i]);
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [63:0] cosine(longint d28);
      logic [63:0] u;
      if (d28 <= 0) return 0;
      u = 64'(d28) * 4;
      return (u > Q30) ? Q30 : u;
    endfunction

    function logic [63:0] project(longint d28, logic [63:0] len21);
      logic [63:0] u;
      if (d28 <= 0 || len21 == 0) return 0;
      u = (64'(d28) << 23) / len21;
      return (u > Q30) ? Q30 : u;
    endfunction

    function logic [63:0] masking(logic [63:0] c, logic [63:0] k);
      return (c << 30) / (fmul(c, Q30 - k) + k);
    endfunction

    function logic [15:0] round_q15(logic [63:0] v);
      if (v > Q30) v = Q30;
      return 16'((v + 64'h4000) >> 15);
    endfunction

    function shade_t shade_query(query_t q);
      shade_t s;
      longint wo[3], wi[3], nv[3], h[3];
      logic [63:0] diff[3];
      logic [63:0] rough, metal, len21, nh, hv, ndv, ndl, r2, alpha2, nh2, t;
      logic [63:0] dden, dterm, mq, f0, om, p2, p5, fterm, rp, k, gterm;
      logic [63:0] num, den, spec, kd;
      rough = clip_q15(REG_ROUGH);
      metal = clip_q15(REG_METAL);
      for (int c = 0; c < 3; c++) diff[c] = fmul(clip_q15(c) << 15, INV_PI_C);
      if (rough >= ROUGH_LIMIT && metal <= METAL_LIMIT) begin
        s.red = round_q15(diff[0]);
        s.green = round_q15(diff[1]);
        s.blue = round_q15(diff[2]);
        s.lambert = 1'b1;
        return s;
      end
      for (int c = 0; c < 3; c++) begin
        wo[c] = q.comp[c];
        wi[c] = q.comp[3 + c];
        nv[c] = q.comp[6 + c];
        h[c]  = wo[c] + wi[c];
      end
      len21  = int_sqrt(64'(h[0]*h[0] + h[1]*h[1] + h[2]*h[2]) << 14);
      nh     = project(nv[0]*h[0] + nv[1]*h[1] + nv[2]*h[2], len21);
      hv     = project(h[0]*wo[0] + h[1]*wo[1] + h[2]*wo[2], len21);
      ndv    = cosine(wo[0]*nv[0] + wo[1]*nv[1] + wo[2]*nv[2]);
      ndl    = cosine(wi[0]*nv[0] + wi[1]*nv[1] + wi[2]*nv[2]);
      r2     = rough * rough;
      alpha2 = (r2 * r2) >> 30;
      nh2    = fmul(nh, nh);
      t      = Q30 - fmul(nh2, Q30 - alpha2);
      dden   = fmul(fmul(t, t), PI_C) + EPS_D;
      dterm  = (alpha2 << 30) / dden;
      mq     = metal << 15;
      f0     = F0_C + fmul(Q30 - F0_C, mq);
      om     = Q30 - hv;
      p2     = fmul(om, om);
      p5     = fmul(fmul(p2, p2), om);
      fterm  = f0 + fmul(Q30 - f0, p5);
      rp     = rough + 64'd32768;
      k      = (rp * rp + 4) >> 3;
      gterm  = fmul(masking(ndl, k), masking(ndv, k));
      num    = fmul(dterm, fmul(fterm, gterm));
      den    = 4 * fmul(ndv, ndl) + EPS_DEN;
      spec   = (num >= den) ? Q30 : (num << 30) / den;
      kd     = fmul(Q30 - fterm, Q30 - mq);
      s.red   = round_q15(fmul(kd, diff[0]) + spec);
      s.green = round_q15(fmul(kd, diff[1]) + spec);
      s.blue  = round_q15(fmul(kd, diff[2]) + spec);
      s.lambert = 1'b0;
      return s;
    endfunction

    function void note_query(query_t q);
      pending_shades.push_back(shade_query(q));
    endfunction

    function void check_result(shade_t got);
      shade_t exp_s;
      if (pending_shades.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
        return;
      end
      exp_s = pending_shades.pop_front();
      checked++;
      if (got.lambert) lambert_seen++;
      if (got.red !== exp_s.red) begin
        $error("refl_red expected %0d got %0d", exp_s.red, got.red);
        errors++;
      end
      if (got.green !== exp_s.green) begin
        $error("refl_green expected %0d got %0d", exp_s.green, got.green);
        errors++;
      end
      if (got.blue !== exp_s.blue) begin
        $error("refl_blue expected %0d got %0d", exp_s.blue, got.blue);
        errors++;
      end
      if (got.lambert !== exp_s.lambert) begin
        $error("lambert_only expected %0d got %0d", exp_s.lambert, got.lambert);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] comp_q[9];
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               done_o;
  logic [15:0]        refl_red_o, refl_green_o, refl_blue_o;
  logic               lambert_only_o;

  brdf_scoreboard sb = new();
  int             cycles = 0;
  int             sent = 0;
  bit             burst = 0;

  initial foreach (comp_q[i]) comp_q[i] = '0;

  always #1 clk_i = ~clk_i;

  cook_torrance_brdf_eval_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .view_x_i(comp_q[0]), .view_y_i(comp_q[1]), .view_z_i(comp_q[2]),
    .light_x_i(comp_q[3]), .light_y_i(comp_q[4]), .light_z_i(comp_q[5]),
    .surf_normal_x_i(comp_q[6]), .surf_normal_y_i(comp_q[7]),
    .surf_normal_z_i(comp_q[8]),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .refl_red_o, .refl_green_o, .refl_blue_o, .lambert_only_o
  );

  always @(posedge clk_i) begin
    shade_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb NOT OK");
      $finish;
    end
    if (rst_ni && done_o) begin
      got.red = refl_red_o;
      got.green = refl_green_o;
      got.blue = refl_blue_o;
      got.lambert = lambert_only_o;
      sb.check_result(got);
    end
  end

  // one start transfer; start stays high across back-to-back items
  task automatic send_query(query_t q);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i = 1'b1;
    foreach (comp_q[i]) comp_q[i] = q.comp[i];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_query(q);
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_shades.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_material(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              logic [15:0] metal, logic [15:0] rough);
    wait_idle();
    write_reg(REG_ALB_RED, r);
    write_reg(REG_ALB_GREEN, g);
    write_reg(REG_ALB_BLUE, b);
    write_reg(REG_METAL, metal);
    write_reg(REG_ROUGH, rough);
  endtask

  function automatic real rnd_unit();
    return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
  endfunction

  // random Q1.14 unit vector
  function automatic void rand_dir(output logic signed [15:0] v[3]);
    real x, y, z, n;
    do begin
      x = rnd_unit(); y = rnd_unit(); z = rnd_unit();
      n = $sqrt(x*x + y*y + z*z);
    end while (n < 0.05 || n > 1.0);
    v[0] = 16'($rtoi(x / n * 16384.0));
    v[1] = 16'($rtoi(y / n * 16384.0));
    v[2] = 16'($rtoi(z / n * 16384.0));
  endfunction

  function automatic query_t make_query(int flavor);
    query_t q;
    logic signed [15:0] vw[3], lt[3], nm[3];
    longint d;
    rand_dir(vw); rand_dir(lt); rand_dir(nm);
    if (flavor < 75) begin
      // well-formed: view and light mostly on the normal's side
      d = vw[0]*nm[0] + vw[1]*nm[1] + vw[2]*nm[2];
      if (d < 0 && $urandom_range(0, 9) != 0) foreach (vw[i]) vw[i] = -vw[i];
      d = lt[0]*nm[0] + lt[1]*nm[1] + lt[2]*nm[2];
      if (d < 0 && $urandom_range(0, 9) != 0) foreach (lt[i]) lt[i] = -lt[i];
      if (flavor < 8) lt = vw;
      else if (flavor < 14) vw = nm;
    end else if (flavor < 85) begin
      foreach (lt[i]) lt[i] = -vw[i];  // half vector cancels
    end
    for (int i = 0; i < 3; i++) begin
      q.comp[i] = vw[i];
      q.comp[3 + i] = lt[i];
      q.comp[6 + i] = nm[i];
    end
    if (flavor >= 85) foreach (q.comp[i]) q.comp[i] = 16'($urandom);
    return q;
  endfunction

  function automatic query_t fixed_query(logic signed [15:0] v0, v1, v2,
                                         logic signed [15:0] l0, l1, l2,
                                         logic signed [15:0] n0, n1, n2);
    query_t q;
    q.comp = '{v0, v1, v2, l0, l1, l2, n0, n1, n2};
    return q;
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      send_query(make_query($urandom_range(0, 99)));
    end
    burst = 0;
  endtask

  task automatic directed_run();
    send_query(fixed_query(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
    send_query(fixed_query(16384, 0, 0, -16384, 0, 0, 0, 0, 16384));
    send_query(fixed_query(0, 0, -16384, 0, 0, -16384, 0, 0, 16384));
    send_query(fixed_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(fixed_query(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_query(fixed_query(11585, 0, 11585, -11585, 0, 11585, 0, 0, 16384));
    send_query(fixed_query(16383, 0, 181, -16383, 0, 181, 0, 0, 16384));
    send_query(fixed_query(-16384, -16384, -16384, -16384, -16384, -16384,
                           -16384, -16384, -16384));
    send_query(fixed_query(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767));
    send_query(fixed_query(-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, -32768, -32768));
    send_query(fixed_query(32767, -32768, 16384, -1, 1, -16384, 16384, -1, 32767));
    send_query(fixed_query(0, 16384, 0, 0, 16384, 0, 0, 16384, 0));
    send_query(fixed_query(0, 11585, 11585, 0, -11585, 11585, 0, 0, 16384));
    send_query(fixed_query(9459, 9459, 9459, 9459, -9459, 9459, 0, 0, 16384));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset material takes the lambert shortcut
    directed_run();
    random_run(20);

    set_material(16'd32768, 16'd32768, 16'd32768, 16'd0, 16'd0);
    directed_run();
    random_run(70);
    set_material(16'd0, 16'd16384, 16'd32768, 16'd32768, 16'd32768);
    directed_run();
    random_run(70);
    set_material(16'd20000, 16'd1000, 16'd30000, 16'd3276, 16'd29492);
    random_run(30);
    set_material(16'd20000, 16'd1000, 16'd30000, 16'd3277, 16'd29492);
    random_run(50);
    set_material(16'd20000, 16'd1000, 16'd30000, 16'd3276, 16'd29491);
    random_run(50);
    set_material(16'd65535, 16'd40000, 16'd0, 16'd65535, 16'd65535);
    random_run(50);
    set_material(16'd12000, 16'd25000, 16'd5000, 16'd8000, 16'd6000);
    // writes to unused indexes must leave the material alone
    for (int idx = NUM_REGS; idx < 8; idx++) write_reg(3'(idx), 16'($urandom));
    random_run(70);
    for (int p = 0; p < 4; p++) begin
      set_material(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                   16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                   16'($urandom_range(0, 32768)));
      random_run(60);
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("sent %0d queries across 12 material settings, %0d results checked",
             sent, sb.checked);
    $display("%0d results took the lambert shortcut, %0d mismatches",
             sb.lambert_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_shades.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
